[sv/rtpd_pkg.sv]
// Shared constants and types for the radial-tangential point distortion block.
// No dependencies; the top level, rtpd_core and the testbench refer to this package by scoped names.
package rtpd_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 28;

    // register stages from the input capture to the last sum (t0 .. t12)
    localparam int PIPE_STAGES = 13;

    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_K1 = 2'd0,
        REG_K2 = 2'd1,
        REG_P1 = 2'd2,
        REG_P2 = 2'd3
    } cfg_reg_t;

endpackage

[sv/radtan_point_distortion.sv]
// Top level of the radial-tangential point distortion block: coefficient
// registers, datapath and output skid. Uses rtpd_pkg, rtpd_core, rtpd_skid.
//
// Usage:
//   s_ channel: one word per point, pos_x in the low half of s_tdata, pos_y above.
//   m_ channel: out_x, out_y, jac_xx, jac_xy, jac_yy packed from the low bits of
//   m_tdata; m_tuser carries the overflow flag (any saturation for that point).
//   cfg_ channel: index 0..3 selects k1, k2, p1, p2; cfg_ready is always high.
//   Write coefficients only while no point is in flight.
// Timing:
//   Points pass through the 13-stage datapath (four chained multiplies plus
//   the sums), then through the output register of the skid.
//   Throughput is one point per cycle while the output is not stalled.
// Reset and stalls:
//   aresetn (synchronous, low) clears coefficients to zero and empties the
//   pipeline. When m_tready is low the output word holds, one more word
//   lands in the skid entry, then s_tready drops and the whole pipeline
//   freezes until the output drains; nothing is lost or repeated.
module radtan_point_distortion #(
    parameter int WORD_BITS = rtpd_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = rtpd_pkg::DEF_FRAC_BITS,
    localparam int S_TDATA_W = ((2 * WORD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((5 * WORD_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_TDATA_W-1:0]              s_tdata,   // pos_x, pos_y
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_TDATA_W-1:0]              m_tdata,   // out_x, out_y, jac_xx, jac_xy, jac_yy
    output logic                              m_tuser,   // overflow
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rtpd_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]              cfg_data
);

    localparam int W  = WORD_BITS;
    localparam int PW = 5 * W + 1;

    logic [W-1:0] k1_reg, k1_next, k2_reg, k2_next;
    logic [W-1:0] p1_reg, p1_next, p2_reg, p2_next;

    logic         en;
    logic         core_valid;
    logic [W-1:0] out_x, out_y, jac_xx, jac_xy, jac_yy;
    logic         overflow;
    logic [PW-1:0] skid_out;

    assign cfg_ready = 1'b1;

    always_comb begin
        k1_next = k1_reg;
        k2_next = k2_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        if (cfg_valid) begin
            case (rtpd_pkg::cfg_reg_t'(cfg_index))
                rtpd_pkg::REG_K1: k1_next = cfg_data;
                rtpd_pkg::REG_K2: k2_next = cfg_data;
                rtpd_pkg::REG_P1: p1_next = cfg_data;
                rtpd_pkg::REG_P2: p2_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_reg <= '0;
            k2_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
        end else begin
            k1_reg <= k1_next;
            k2_reg <= k2_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    rtpd_core #(
        .WORD_BITS(W),
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .pos_x        (s_tdata[W-1:0]),
        .pos_y        (s_tdata[2*W-1:W]),
        .radial_k1    (k1_reg),
        .radial_k2    (k2_reg),
        .tangential_p1(p1_reg),
        .tangential_p2(p2_reg),
        .out_valid    (core_valid),
        .out_x        (out_x),
        .out_y        (out_y),
        .jac_xx       (jac_xx),
        .jac_xy       (jac_xy),
        .jac_yy       (jac_yy),
        .overflow     (overflow)
    );

    rtpd_skid #(
        .WIDTH(PW)
    ) u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (core_valid),
        .in_ready (en),
        .in_data  ({overflow, jac_yy, jac_xy, jac_xx, out_y, out_x}),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (skid_out)
    );

    assign s_tready = en;
    assign m_tdata  = M_TDATA_W'(skid_out[5*W-1:0]);
    assign m_tuser  = skid_out[5*W];

    // skid entry only fills behind a held output word
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("skid entry full while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input side stalled without an output stall");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

endmodule

[sv/rtpd_delay.sv]
// Enabled shift line that aligns words between pipeline stages.
// Depends on nothing; used by rtpd_core.
module rtpd_delay #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

[sv/rtpd_mul.sv]
// Two-stage fixed point multiplier: split partial products, then round half
// away from zero and saturate. Overflow flag travels in the top bit.
// Depends on nothing; used by rtpd_core.
module rtpd_mul #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 28
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [WORD_BITS:0] a,
    input  logic [WORD_BITS:0] b,
    output logic [WORD_BITS:0] p
);

    localparam int W  = WORD_BITS;
    localparam int H  = W / 2;
    localparam int HB = W - H;
    localparam int LW = W + H + 1;
    localparam int UW = W + HB;
    localparam int PW = 2 * W + 1;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [LW-1:0] pp_lo_reg, pp_lo_next;
    logic signed [UW-1:0] pp_hi_reg, pp_hi_next;
    logic                 ovf1_reg, ovf1_next;
    logic [W-1:0]         p_reg, p_next;
    logic                 ovf2_reg, ovf2_next;

    logic [PW-1:0]        full;
    logic [PW-1:0]        rnd;
    logic signed [PW-1:0] sh;
    logic                 sat;

    always_comb begin
        pp_lo_next = $signed(a[W-1:0]) * $signed({1'b0, b[H-1:0]});
        pp_hi_next = $signed(a[W-1:0]) * $signed(b[W-1:H]);
        ovf1_next  = a[W] | b[W];
    end

    always_comb begin
        full = ({{(PW-UW){pp_hi_reg[UW-1]}}, pp_hi_reg} << H)
             + {{(PW-LW){pp_lo_reg[LW-1]}}, pp_lo_reg};
        // negative products round with half minus one ulp: ties go away from zero
        rnd  = full + HALF - PW'(full[PW-1]);
        sh   = $signed(rnd) >>> FRAC_BITS;
        sat  = (sh[PW-1:W-1] != {(PW-W+1){sh[W-1]}});
        p_next    = sat ? (sh[PW-1] ? WMIN : WMAX) : sh[W-1:0];
        ovf2_next = ovf1_reg | sat;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
            ovf1_reg  <= ovf1_next;
            p_reg     <= p_next;
            ovf2_reg  <= ovf2_next;
        end
    end

    assign p = {ovf2_reg, p_reg};

endmodule

[sv/rtpd_skid.sv]
// Output register with one skid entry; parts the pipeline enable from m_tready.
// Depends on nothing; used by the top level.
module rtpd_skid #(
    parameter int WIDTH = 161
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             out_vld_reg, out_vld_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;
    logic             skid_vld_reg, skid_vld_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;

    assign in_ready = ~skid_vld_reg;

    always_comb begin
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        if (out_ready || !out_vld_reg) begin
            if (skid_vld_reg) begin
                out_vld_next  = 1'b1;
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end else begin
                out_vld_next  = in_valid;
                out_data_next = in_data;
            end
        end else if (in_valid && !skid_vld_reg) begin
            skid_vld_next  = 1'b1;
            skid_data_next = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/rtpd_core.sv]
// Distortion datapath: 13 register stages of multiplies, scalings and
// saturating sums. Uses rtpd_pkg, rtpd_mul and rtpd_delay.
module rtpd_core #(
    parameter int WORD_BITS = rtpd_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = rtpd_pkg::DEF_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [WORD_BITS-1:0] pos_x,
    input  logic [WORD_BITS-1:0] pos_y,
    input  logic [WORD_BITS-1:0] radial_k1,
    input  logic [WORD_BITS-1:0] radial_k2,
    input  logic [WORD_BITS-1:0] tangential_p1,
    input  logic [WORD_BITS-1:0] tangential_p2,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] out_x,
    output logic [WORD_BITS-1:0] out_y,
    output logic [WORD_BITS-1:0] jac_xx,
    output logic [WORD_BITS-1:0] jac_xy,
    output logic [WORD_BITS-1:0] jac_yy,
    output logic                 overflow
);

    localparam int W  = WORD_BITS;
    localparam int NS = rtpd_pkg::PIPE_STAGES;
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_V = (FRAC_BITS >= W - 1) ? WMAX : (W'(1) << FRAC_BITS);
    localparam logic [2:0] C_TWO  = 3'd2;
    localparam logic [2:0] C_FOUR = 3'd4;
    localparam logic [2:0] C_SIX  = 3'd6;

    // word with its sticky saturation flag
    typedef struct packed {
        logic         ovf;
        logic [W-1:0] v;
    } fix_t;

    function automatic fix_t sadd(fix_t a, fix_t b);
        logic [W:0] s;
        logic       o;
        fix_t       r;
        s = {a.v[W-1], a.v} + {b.v[W-1], b.v};
        o = (s[W] != s[W-1]);
        r.ovf = a.ovf | b.ovf | o;
        r.v   = o ? (s[W] ? WMIN : WMAX) : s[W-1:0];
        return r;
    endfunction

    // exact scaling by 2, 4 or 6, then saturate
    function automatic fix_t cmul(fix_t a, logic [2:0] c);
        logic [W+2:0] e;
        logic [W+2:0] p;
        logic         o;
        fix_t         r;
        e = {{3{a.v[W-1]}}, a.v};
        p = (c[2] ? (e << 2) : '0) + (c[1] ? (e << 1) : '0);
        o = (p[W+2:W-1] != {4{p[W-1]}});
        r.ovf = a.ovf | o;
        r.v   = o ? (p[W+2] ? WMIN : WMAX) : p[W-1:0];
        return r;
    endfunction

    fix_t k1f, k2f, p1f, p2f, one_f;

    assign k1f   = '{ovf: 1'b0, v: radial_k1};
    assign k2f   = '{ovf: 1'b0, v: radial_k2};
    assign p1f   = '{ovf: 1'b0, v: tangential_p1};
    assign p2f   = '{ovf: 1'b0, v: tangential_p2};
    assign one_f = '{ovf: 1'b0, v: ONE_V};

    logic [NS-1:0] vld_reg, vld_next;

    // t0
    fix_t x0_reg, x0_next, y0_reg, y0_next;
    // t2 (multiplier outputs)
    fix_t x2, y2, xy, p1x, p1y, p2x, p2y;
    // t3
    fix_t r2_reg, r2_next, x2_dbl_reg, x2_dbl_next, y2_dbl_reg, y2_dbl_next;
    fix_t jxy_p1_reg, jxy_p1_next, jxy_p2_reg, jxy_p2_next;
    fix_t jx_a_reg, jx_a_next, jx_b_reg, jx_b_next;
    fix_t jy_a_reg, jy_a_next, jy_b_reg, jy_b_next;
    // t4
    fix_t p1xy, p2xy;
    fix_t bx_reg, bx_next, by_reg, by_next, jxy_a_reg, jxy_a_next;
    // t5
    fix_t k1r2, k2r2, r4;
    fix_t a1_reg, a1_next, a2_reg, a2_next;
    // t6
    fix_t tx, ty;
    fix_t rad_a_reg, rad_a_next, s_a_reg, s_a_next, s_b_reg, s_b_next;
    // t7
    fix_t k2r4;
    fix_t s_reg, s_next, rad_a_d_reg, rad_a_d_next;
    // t8
    fix_t rad_reg, rad_next;
    // t9
    fix_t x2s, xys, y2s;
    fix_t jx1_reg, jx1_next, jy1_reg, jy1_next;
    // t10
    fix_t xrad, yrad;
    fix_t jx2_reg, jx2_next, jy2_reg, jy2_next;
    fix_t x2s_d_reg, x2s_d_next, xys_d_reg, xys_d_next, y2s_d_reg, y2s_d_next;
    // t11
    fix_t jxx_reg, jxx_next, jxy_reg, jxy_next, jyy_reg, jyy_next;
    fix_t ox1_reg, ox1_next, oy1_reg, oy1_next;
    // t12
    fix_t ox_reg, ox_next, oy_reg, oy_next;
    fix_t jxx_o_reg, jxx_o_next, jxy_o_reg, jxy_o_next, jyy_o_reg, jyy_o_next;

    // aligned copies
    fix_t [1:0] pos_d8;
    fix_t [2:0] sq_d5;
    fix_t [1:0] ja_d5;
    fix_t [1:0] jb_d6;
    fix_t jxy_a_d6, a1_d5, ty_d4, tx_d5, a2_d6;

    // multipliers
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_x2 (
        .aclk(aclk), .en(en), .a(x0_reg), .b(x0_reg), .p(x2));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_y2 (
        .aclk(aclk), .en(en), .a(y0_reg), .b(y0_reg), .p(y2));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_xy (
        .aclk(aclk), .en(en), .a(x0_reg), .b(y0_reg), .p(xy));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_p1x (
        .aclk(aclk), .en(en), .a(p1f), .b(x0_reg), .p(p1x));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_p1y (
        .aclk(aclk), .en(en), .a(p1f), .b(y0_reg), .p(p1y));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_p2x (
        .aclk(aclk), .en(en), .a(p2f), .b(x0_reg), .p(p2x));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_p2y (
        .aclk(aclk), .en(en), .a(p2f), .b(y0_reg), .p(p2y));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_p1xy (
        .aclk(aclk), .en(en), .a(p1f), .b(xy), .p(p1xy));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_p2xy (
        .aclk(aclk), .en(en), .a(p2f), .b(xy), .p(p2xy));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_k1r2 (
        .aclk(aclk), .en(en), .a(k1f), .b(r2_reg), .p(k1r2));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_k2r2 (
        .aclk(aclk), .en(en), .a(k2f), .b(r2_reg), .p(k2r2));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_r4 (
        .aclk(aclk), .en(en), .a(r2_reg), .b(r2_reg), .p(r4));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_tx (
        .aclk(aclk), .en(en), .a(p2f), .b(bx_reg), .p(tx));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_ty (
        .aclk(aclk), .en(en), .a(p1f), .b(by_reg), .p(ty));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_k2r4 (
        .aclk(aclk), .en(en), .a(k2f), .b(r4), .p(k2r4));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_x2s (
        .aclk(aclk), .en(en), .a(sq_d5[0]), .b(s_reg), .p(x2s));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_xys (
        .aclk(aclk), .en(en), .a(sq_d5[1]), .b(s_reg), .p(xys));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_y2s (
        .aclk(aclk), .en(en), .a(sq_d5[2]), .b(s_reg), .p(y2s));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_xrad (
        .aclk(aclk), .en(en), .a(pos_d8[0]), .b(rad_reg), .p(xrad));
    rtpd_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_yrad (
        .aclk(aclk), .en(en), .a(pos_d8[1]), .b(rad_reg), .p(yrad));

    // alignment lines
    rtpd_delay #(.WIDTH(2*(W+1)), .DEPTH(8)) u_d_pos (
        .aclk(aclk), .en(en), .d({y0_reg, x0_reg}), .q(pos_d8));
    rtpd_delay #(.WIDTH(3*(W+1)), .DEPTH(5)) u_d_sq (
        .aclk(aclk), .en(en), .d({y2, xy, x2}), .q(sq_d5));
    rtpd_delay #(.WIDTH(2*(W+1)), .DEPTH(5)) u_d_ja (
        .aclk(aclk), .en(en), .d({jy_a_reg, jx_a_reg}), .q(ja_d5));
    rtpd_delay #(.WIDTH(2*(W+1)), .DEPTH(6)) u_d_jb (
        .aclk(aclk), .en(en), .d({jy_b_reg, jx_b_reg}), .q(jb_d6));
    rtpd_delay #(.WIDTH(W+1), .DEPTH(6)) u_d_jxy (
        .aclk(aclk), .en(en), .d(jxy_a_reg), .q(jxy_a_d6));
    rtpd_delay #(.WIDTH(W+1), .DEPTH(5)) u_d_a1 (
        .aclk(aclk), .en(en), .d(a1_reg), .q(a1_d5));
    rtpd_delay #(.WIDTH(W+1), .DEPTH(6)) u_d_a2 (
        .aclk(aclk), .en(en), .d(a2_reg), .q(a2_d6));
    rtpd_delay #(.WIDTH(W+1), .DEPTH(4)) u_d_ty (
        .aclk(aclk), .en(en), .d(ty), .q(ty_d4));
    rtpd_delay #(.WIDTH(W+1), .DEPTH(5)) u_d_tx (
        .aclk(aclk), .en(en), .d(tx), .q(tx_d5));

    always_comb begin
        vld_next = {vld_reg[NS-2:0], in_valid};

        x0_next = '{ovf: 1'b0, v: pos_x};
        y0_next = '{ovf: 1'b0, v: pos_y};

        r2_next     = sadd(x2, y2);
        x2_dbl_next = cmul(x2, C_TWO);
        y2_dbl_next = cmul(y2, C_TWO);
        jxy_p1_next = cmul(p1x, C_TWO);
        jxy_p2_next = cmul(p2y, C_TWO);
        jx_a_next   = cmul(p1y, C_TWO);
        jx_b_next   = cmul(p2x, C_SIX);
        jy_a_next   = cmul(p1y, C_SIX);
        jy_b_next   = cmul(p2x, C_TWO);

        bx_next    = sadd(r2_reg, x2_dbl_reg);
        by_next    = sadd(r2_reg, y2_dbl_reg);
        jxy_a_next = sadd(jxy_p1_reg, jxy_p2_reg);

        a1_next = cmul(p1xy, C_TWO);
        a2_next = cmul(p2xy, C_TWO);

        rad_a_next = sadd(one_f, k1r2);
        s_a_next   = cmul(k1f, C_TWO);
        s_b_next   = cmul(k2r2, C_FOUR);

        s_next       = sadd(s_a_reg, s_b_reg);
        rad_a_d_next = rad_a_reg;

        rad_next = sadd(rad_a_d_reg, k2r4);

        jx1_next = sadd(rad_reg, ja_d5[0]);
        jy1_next = sadd(rad_reg, ja_d5[1]);

        jx2_next   = sadd(jx1_reg, jb_d6[0]);
        jy2_next   = sadd(jy1_reg, jb_d6[1]);
        x2s_d_next = x2s;
        xys_d_next = xys;
        y2s_d_next = y2s;

        jxx_next = sadd(jx2_reg, x2s_d_reg);
        jyy_next = sadd(jy2_reg, y2s_d_reg);
        jxy_next = sadd(jxy_a_d6, xys_d_reg);
        ox1_next = sadd(xrad, a1_d5);
        oy1_next = sadd(yrad, ty_d4);

        ox_next    = sadd(ox1_reg, tx_d5);
        oy_next    = sadd(oy1_reg, a2_d6);
        jxx_o_next = jxx_reg;
        jxy_o_next = jxy_reg;
        jyy_o_next = jyy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg      <= x0_next;
            y0_reg      <= y0_next;
            r2_reg      <= r2_next;
            x2_dbl_reg  <= x2_dbl_next;
            y2_dbl_reg  <= y2_dbl_next;
            jxy_p1_reg  <= jxy_p1_next;
            jxy_p2_reg  <= jxy_p2_next;
            jx_a_reg    <= jx_a_next;
            jx_b_reg    <= jx_b_next;
            jy_a_reg    <= jy_a_next;
            jy_b_reg    <= jy_b_next;
            bx_reg      <= bx_next;
            by_reg      <= by_next;
            jxy_a_reg   <= jxy_a_next;
            a1_reg      <= a1_next;
            a2_reg      <= a2_next;
            rad_a_reg   <= rad_a_next;
            s_a_reg     <= s_a_next;
            s_b_reg     <= s_b_next;
            s_reg       <= s_next;
            rad_a_d_reg <= rad_a_d_next;
            rad_reg     <= rad_next;
            jx1_reg     <= jx1_next;
            jy1_reg     <= jy1_next;
            jx2_reg     <= jx2_next;
            jy2_reg     <= jy2_next;
            x2s_d_reg   <= x2s_d_next;
            xys_d_reg   <= xys_d_next;
            y2s_d_reg   <= y2s_d_next;
            jxx_reg     <= jxx_next;
            jxy_reg     <= jxy_next;
            jyy_reg     <= jyy_next;
            ox1_reg     <= ox1_next;
            oy1_reg     <= oy1_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            jxx_o_reg   <= jxx_o_next;
            jxy_o_reg   <= jxy_o_next;
            jyy_o_reg   <= jyy_o_next;
        end
    end

    // every intermediate feeds some output, so the sticky flags cover all steps
    assign out_valid = vld_reg[NS-1];
    assign out_x     = ox_reg.v;
    assign out_y     = oy_reg.v;
    assign jac_xx    = jxx_o_reg.v;
    assign jac_xy    = jxy_o_reg.v;
    assign jac_yy    = jyy_o_reg.v;
    assign overflow  = ox_reg.ovf | oy_reg.ovf | jxx_o_reg.ovf | jxy_o_reg.ovf | jyy_o_reg.ovf;

endmodule

[tb/tb_radtan_point_distortion.sv]
// Self-checking testbench for radtan_point_distortion: directed points, then random
// points under several coefficient sets, checked against an in-bench fixed-point predictor.
// Depends on rtpd_pkg and the radtan_point_distortion RTL only.
`timescale 1ns / 100ps

module tb_radtan_point_distortion;

    localparam int W = rtpd_pkg::DEF_WORD_BITS;
    localparam int FRAC = rtpd_pkg::DEF_FRAC_BITS;
    localparam int S_W = ((2 * W + 7) / 8) * 8;
    localparam int M_W = ((5 * W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400_000;
    localparam longint WMAX = (longint'(1) <<< (W - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;
    localparam int POINTS_PER_PHASE = 225;
    localparam int N_ROWS = 20;

    typedef logic signed [W-1:0] word_t;

    localparam word_t ONE = word_t'(longint'(1) <<< FRAC);
    localparam word_t TOP = word_t'(WMAX);
    localparam word_t BOT = word_t'(WMIN);

    // out_x, out_y, jac_xx, jac_xy, jac_yy in f[0..4]
    typedef struct {
        word_t f [5];
        logic  ovf;
    } distorted_t;

    typedef struct {
        int    cset;
        word_t x;
        word_t y;
        bit    typed;
        word_t ox;
        word_t oy;
        word_t jxx;
        word_t jxy;
        word_t jyy;
        logic  ovf;
    } point_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [S_W-1:0]     s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    logic [M_W-1:0]     m_tdata;
    logic               m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    rtpd_pkg::cfg_reg_t cfg_index = rtpd_pkg::REG_K1;
    logic [W-1:0]       cfg_data = '0;

    radtan_point_distortion dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("tb_radtan_point_distortion: FAIL");
        $finish;
    end

    // bench copy of the coefficients
    word_t coef_k1 = '0;
    word_t coef_k2 = '0;
    word_t coef_p1 = '0;
    word_t coef_p2 = '0;

    distorted_t distortions_due [$];
    int  errors = 0;
    bit  sat_hit;
    bit  src_idle = 1'b1;
    bit  sink_idle = 1'b1;

    string field_names [5] = '{"out_x", "out_y", "jac_xx", "jac_xy", "jac_yy"};

    word_t coef_sets [5][4] = '{
        '{32'sd0, 32'sd0, 32'sd0, 32'sd0},
        '{-32'sd80530637, 32'sd26843546, 32'sd268435, -32'sd536871},
        '{TOP, TOP, TOP, TOP},
        '{BOT, BOT, BOT, BOT},
        '{32'sd0, 32'sd0, ONE, -ONE}
    };

    // set 0 is the reset state: results readable directly
    point_row_t directed_rows [N_ROWS] = '{
        '{0, 32'sd0, 32'sd0,       1, 32'sd0, 32'sd0, ONE, 32'sd0, ONE, 1'b0},
        '{0, ONE,    32'sd0,       1, ONE,    32'sd0, ONE, 32'sd0, ONE, 1'b0},
        '{0, 32'sd0, -ONE,         1, 32'sd0, -ONE,   ONE, 32'sd0, ONE, 1'b0},
        '{0, 32'sd1, -32'sd1,      1, 32'sd1, -32'sd1, ONE, 32'sd0, ONE, 1'b0},
        '{0, TOP,    32'sd0,       1, TOP,    32'sd0, ONE, 32'sd0, ONE, 1'b1},
        '{0, BOT,    BOT,          1, BOT,    BOT,    ONE, 32'sd0, ONE, 1'b1},
        '{0, TOP,    BOT,          1, TOP,    BOT,    ONE, 32'sd0, ONE, 1'b1},
        '{1, 32'sd134217728, 32'sd67108864,     0, 0, 0, 0, 0, 0, 1'b0},
        '{1, -32'sd187904819, 32'sd241591910,   0, 0, 0, 0, 0, 0, 1'b0},
        '{1, 32'sd322122547, -32'sd295279002,   0, 0, 0, 0, 0, 0, 1'b0},
        '{1, -32'sd13421773, -32'sd5368709,     0, 0, 0, 0, 0, 0, 1'b0},
        // xy lands exactly on a rounding tie
        '{4, 32'sd16384,  32'sd8192,            0, 0, 0, 0, 0, 0, 1'b0},
        '{4, -32'sd16384, 32'sd8192,            0, 0, 0, 0, 0, 0, 1'b0},
        '{4, 32'sd16384,  -32'sd24576,          0, 0, 0, 0, 0, 0, 1'b0},
        '{2, ONE,    ONE,                       0, 0, 0, 0, 0, 0, 1'b0},
        '{2, TOP,    TOP,                       0, 0, 0, 0, 0, 0, 1'b0},
        '{2, -ONE,   32'sd134217728,            0, 0, 0, 0, 0, 0, 1'b0},
        '{3, BOT,    TOP,                       0, 0, 0, 0, 0, 0, 1'b0},
        '{3, 32'sd26843546, -32'sd26843546,     0, 0, 0, 0, 0, 0, 1'b0},
        '{3, 32'sd0, 32'sd0,                    0, 0, 0, 0, 0, 0, 1'b0}
    };

    function automatic longint clamp_word(longint v);
        if (v > WMAX) begin
            sat_hit = 1'b1;
            return WMAX;
        end
        if (v < WMIN) begin
            sat_hit = 1'b1;
            return WMIN;
        end
        return v;
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return clamp_word(a + b);
    endfunction

    function automatic longint fx_scale(longint c, longint a);
        return clamp_word(c * a);
    endfunction

    // round magnitude half away from zero, then clamp
    function automatic longint fx_mul(longint a, longint b);
        longint mag;
        longint lim;
        bit     neg;
        neg = (a < 0) != (b < 0);
        mag = a * b;
        if (mag < 0) mag = -mag;
        mag = (mag + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        lim = neg ? WMAX + 1 : WMAX;
        if (mag > lim) begin
            sat_hit = 1'b1;
            mag = lim;
        end
        return neg ? -mag : mag;
    endfunction

    function automatic distorted_t distort_point(word_t px, word_t py);
        longint x, y, one, k1, k2, p1, p2;
        longint x2, y2, xy, r2, r4, rad, s, ox, oy, jxx, jxy, jyy;
        distorted_t d;
        x = px;
        y = py;
        k1 = coef_k1;
        k2 = coef_k2;
        p1 = coef_p1;
        p2 = coef_p2;
        one = longint'(1) <<< FRAC;
        if (one > WMAX) one = WMAX;
        sat_hit = 1'b0;

        x2 = fx_mul(x, x);
        y2 = fx_mul(y, y);
        xy = fx_mul(x, y);
        r2 = fx_add(x2, y2);
        r4 = fx_mul(r2, r2);
        rad = fx_add(fx_add(one, fx_mul(k1, r2)), fx_mul(k2, r4));

        ox = fx_add(fx_add(fx_mul(x, rad), fx_scale(2, fx_mul(p1, xy))),
                    fx_mul(p2, fx_add(r2, fx_scale(2, x2))));
        oy = fx_add(fx_add(fx_mul(y, rad), fx_mul(p1, fx_add(r2, fx_scale(2, y2)))),
                    fx_scale(2, fx_mul(p2, xy)));

        s = fx_add(fx_scale(2, k1), fx_scale(4, fx_mul(k2, r2)));
        jxx = fx_add(fx_add(fx_add(rad, fx_scale(2, fx_mul(p1, y))),
                            fx_scale(6, fx_mul(p2, x))), fx_mul(x2, s));
        jxy = fx_add(fx_add(fx_scale(2, fx_mul(p1, x)),
                            fx_scale(2, fx_mul(p2, y))), fx_mul(xy, s));
        jyy = fx_add(fx_add(fx_add(rad, fx_scale(6, fx_mul(p1, y))),
                            fx_scale(2, fx_mul(p2, x))), fx_mul(y2, s));

        d.f[0] = ox[W-1:0];
        d.f[1] = oy[W-1:0];
        d.f[2] = jxx[W-1:0];
        d.f[3] = jxy[W-1:0];
        d.f[4] = jyy[W-1:0];
        d.ovf = sat_hit;
        return d;
    endfunction

    function automatic word_t pick_coord();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return word_t'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
        if (sel < 85) return word_t'($urandom);
        case ($urandom_range(0, 5))
            0: return TOP;
            1: return BOT;
            2: return '0;
            3: return ONE;
            4: return -ONE;
            default: return word_t'(int'($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    function automatic word_t pick_coef();
        return word_t'(int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
    endfunction

    task automatic flag_mismatch(string what);
        $display("mismatch @%0d: %s", cycle_count, what);
        errors++;
    endtask

    task automatic check_distortion(logic [M_W-1:0] data, logic ovf);
        distorted_t want;
        if (distortions_due.size() == 0) begin
            flag_mismatch("output word with nothing pending");
            return;
        end
        want = distortions_due.pop_front();
        for (int i = 0; i < 5; i++) begin
            if (data[i*W +: W] !== want.f[i])
                flag_mismatch($sformatf("%s got %h want %h", field_names[i],
                                        data[i*W +: W], want.f[i]));
        end
        if (ovf !== want.ovf)
            flag_mismatch($sformatf("overflow got %b want %b", ovf, want.ovf));
    endtask

    // leaves cfg_valid high; caller drops it
    task automatic cfg_word(rtpd_pkg::cfg_reg_t idx, word_t v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rtpd_pkg::REG_K1: coef_k1 = v;
            rtpd_pkg::REG_K2: coef_k2 = v;
            rtpd_pkg::REG_P1: coef_p1 = v;
            rtpd_pkg::REG_P2: coef_p2 = v;
            default: ;
        endcase
    endtask

    task automatic load_coefs(word_t k1, word_t k2, word_t p1, word_t p2);
        cfg_word(rtpd_pkg::REG_K1, k1);
        cfg_word(rtpd_pkg::REG_K2, k2);
        cfg_word(rtpd_pkg::REG_P1, p1);
        cfg_word(rtpd_pkg::REG_P2, p2);
        cfg_valid <= 1'b0;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (distortions_due.size() != 0) @(posedge aclk);
    endtask

    // leaves s_tvalid high so back-to-back words need no extra edge
    task automatic send_point(word_t px, word_t py, bit typed, distorted_t want);
        int gap;
        gap = src_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        do @(posedge aclk); while (!s_tready);
        distortions_due.push_back(typed ? want : distort_point(px, py));
    endtask

    initial begin
        int hold;
        hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                check_distortion(m_tdata, m_tuser);
                hold = sink_idle ? $urandom_range(0, 9) : 0;
                if (hold != 0) m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (hold <= 1) m_tready <= 1'b1;
                hold--;
            end
        end
    end

    initial begin
        distorted_t want;
        distorted_t none;
        int cur_set;
        none = '{f: '{default: '0}, ovf: 1'b0};
        cur_set = 0;
        aresetn <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].cset != cur_set) begin
                hold_until_drained();
                cur_set = directed_rows[r].cset;
                load_coefs(coef_sets[cur_set][0], coef_sets[cur_set][1],
                           coef_sets[cur_set][2], coef_sets[cur_set][3]);
            end
            want.f[0] = directed_rows[r].ox;
            want.f[1] = directed_rows[r].oy;
            want.f[2] = directed_rows[r].jxx;
            want.f[3] = directed_rows[r].jxy;
            want.f[4] = directed_rows[r].jyy;
            want.ovf = directed_rows[r].ovf;
            send_point(directed_rows[r].x, directed_rows[r].y, directed_rows[r].typed, want);
        end

        for (int p = 0; p < 6; p++) begin
            hold_until_drained();
            case (p)
                0: load_coefs(pick_coef(), pick_coef(), pick_coef() >>> 4, pick_coef() >>> 4);
                1: load_coefs(TOP, TOP, TOP, TOP);
                2: load_coefs(BOT, BOT, BOT, BOT);
                3: load_coefs(word_t'($urandom), word_t'($urandom),
                              word_t'($urandom), word_t'($urandom));
                4: load_coefs(pick_coef(), pick_coef() >>> 2, pick_coef() >>> 6, pick_coef());
                default: load_coefs(BOT, TOP, word_t'($urandom), '0);
            endcase
            src_idle = (p != 2);
            sink_idle = (p != 4);
            for (int i = 0; i < POINTS_PER_PHASE; i++) begin
                if (p == 0 && i == POINTS_PER_PHASE / 2) hold_until_drained();
                send_point(pick_coord(), pick_coord(), 1'b0, none);
            end
        end

        hold_until_drained();
        repeat (rtpd_pkg::PIPE_STAGES + 8) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_radtan_point_distortion: PASS");
        end else begin
            $display("tb_radtan_point_distortion: FAIL");
        end
        $finish;
    end

endmodule

[radtan_point_distortion.f]
sv/rtpd_pkg.sv
sv/rtpd_delay.sv
sv/rtpd_mul.sv
sv/rtpd_skid.sv
sv/rtpd_core.sv
sv/radtan_point_distortion.sv
tb/tb_radtan_point_distortion.sv
